### rtl/mbcr_pkg.sv
package mbcr_pkg;

   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 6;
   localparam int MUX_SETS_W    = 3;
   localparam int INPUT_COUNT_W = 6;
   localparam int SET_W         = 2;
   localparam int PIN_OUT_W     = 6;
   localparam int KEY_W         = 10;
   localparam int QUEUE_DEPTH   = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MUX_SETS    = 1'b0,
      CSR_INPUT_COUNT = 1'b1
   } csr_index_type;

   typedef enum logic {
      BK_IDLE,
      BK_SCAN
   } back_state_type;

   typedef struct packed {
      logic                 event_valid;
      logic [PIN_OUT_W-1:0] pin_index;
      logic [PIN_OUT_W-1:0] scan_code;
      logic [KEY_W-1:0]     key_code;
      logic                 pressed;
      logic                 last;
   } rsp_type;

   localparam logic [KEY_W-1:0] KEY_REG_BASE   = 10'd288;
   localparam logic [KEY_W-1:0] KEY_EXTRA_BASE = 10'd704;
   localparam logic [6:0]       KEY_REG_COUNT  = 7'd16;

   function automatic logic [KEY_W-1:0] key_code_f(input logic [6:0] pin);
      if (pin < KEY_REG_COUNT) begin
         key_code_f = KEY_REG_BASE + KEY_W'(pin);
      end else begin
         key_code_f = KEY_EXTRA_BASE + KEY_W'(pin) - KEY_W'(KEY_REG_COUNT);
      end
   endfunction

endpackage

### rtl/multiplexed_button_change_reporter.sv
// flow: an accepted scan is written into the queue; the back end pops it into the
//   output register as an empty report, or walks it to give an event per changed pin
// throughput: one scan per cycle without changes while the output is not stalled;
//   else the queue waits for the one-pin-per-cycle walker, which a full output stalls
// reset: per-set scan stores cleared to zero, mux_sets = MAX_SETS,
//   input_count = PIN_COUNT, queue and output empty
module multiplexed_button_change_reporter import mbcr_pkg::*; #(
   parameter int PIN_COUNT = 48,
   parameter int MAX_SETS  = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [PIN_COUNT-1:0]   req_scan_bits,
   input  logic [SET_W-1:0]       req_scanned_set,
   input  logic                   req_transfer_error,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_event_valid,
   output logic [PIN_OUT_W-1:0]   rsp_pin_index,
   output logic [PIN_OUT_W-1:0]   rsp_scan_code,
   output logic [KEY_W-1:0]       rsp_key_code,
   output logic                   rsp_pressed,
   output logic                   rsp_last
);

   logic                   q_push, q_space, q_pop, q_avail;
   logic [2*PIN_COUNT-1:0] q_wr_data, q_rd_data;
   rsp_type                rsp;

   mbcr_front #(
      .PIN_COUNT (PIN_COUNT),
      .MAX_SETS  (MAX_SETS)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_scan_bits      (req_scan_bits),
      .req_scanned_set    (req_scanned_set),
      .req_transfer_error (req_transfer_error),
      .q_push             (q_push),
      .q_data             (q_wr_data),
      .q_space            (q_space)
   );

   mbcr_queue #(
      .WIDTH (2*PIN_COUNT)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wr_data),
      .space     (q_space),
      .pop       (q_pop),
      .pop_data  (q_rd_data),
      .avail     (q_avail)
   );

   mbcr_back #(
      .PIN_COUNT (PIN_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_avail   (q_avail),
      .q_data    (q_rd_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_event_valid = rsp.event_valid;
   assign rsp_pin_index   = rsp.pin_index;
   assign rsp_scan_code   = rsp.scan_code;
   assign rsp_key_code    = rsp.key_code;
   assign rsp_pressed     = rsp.pressed;
   assign rsp_last        = rsp.last;

endmodule

### rtl/mbcr_front.sv
module mbcr_front import mbcr_pkg::*; #(
   parameter int PIN_COUNT = 48,
   parameter int MAX_SETS  = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [PIN_COUNT-1:0]     req_scan_bits,
   input  logic [SET_W-1:0]         req_scanned_set,
   input  logic                     req_transfer_error,
   output logic                     q_push,
   output logic [2*PIN_COUNT-1:0]   q_data,
   input  logic                     q_space
);

   logic [MUX_SETS_W:0]      mux_sets_ff, mux_sets_in;
   logic [INPUT_COUNT_W:0]   input_count_ff, input_count_in;
   logic [PIN_COUNT-1:0]     prev_ff [MAX_SETS];
   logic [PIN_COUNT-1:0]     prev_in [MAX_SETS];

   logic [MUX_SETS_W:0]      sets_eff;
   logic [INPUT_COUNT_W:0]   count_eff;
   logic [MUX_SETS_W:0]      set_ext;
   logic                     ignore;
   logic                     accept;
   logic [PIN_COUNT-1:0]     old_scan, others, limit, changed;

   assign csr_ready = 1'b1;

   always_comb begin
      mux_sets_in    = mux_sets_ff;
      input_count_in = input_count_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MUX_SETS:    mux_sets_in = {1'b0, csr_wdata[MUX_SETS_W-1:0]};
            CSR_INPUT_COUNT: input_count_in = {1'b0, csr_wdata[INPUT_COUNT_W-1:0]};
            default: ;
         endcase
      end
   end

   // clamp configuration to usable ranges
   always_comb begin
      if (mux_sets_ff == '0) begin
         sets_eff = (MUX_SETS_W+1)'(1);
      end else if (mux_sets_ff > (MUX_SETS_W+1)'(MAX_SETS)) begin
         sets_eff = (MUX_SETS_W+1)'(MAX_SETS);
      end else begin
         sets_eff = mux_sets_ff;
      end
      if (input_count_ff > (INPUT_COUNT_W+1)'(PIN_COUNT)) begin
         count_eff = (INPUT_COUNT_W+1)'(PIN_COUNT);
      end else begin
         count_eff = input_count_ff;
      end
   end

   assign set_ext = (MUX_SETS_W+1)'(req_scanned_set);
   assign ignore  = req_transfer_error || (set_ext >= sets_eff);
   assign accept  = req_valid && q_space;

   always_comb begin
      old_scan = '0;
      others   = '1;
      for (int s = 0; s < MAX_SETS; s++) begin
         if ((MUX_SETS_W+1)'(s) == set_ext) begin
            old_scan = old_scan | prev_ff[s];
         end else if ((MUX_SETS_W+1)'(s) < sets_eff) begin
            // a change counts only while every other active set reads released
            others = others & prev_ff[s];
         end
      end
      for (int p = 0; p < PIN_COUNT; p++) begin
         limit[p] = ((INPUT_COUNT_W+1)'(p) < count_eff);
      end
      changed = (req_scan_bits ^ old_scan) & others & limit;
   end

   always_comb begin
      prev_in = prev_ff;
      if (accept && !ignore) begin
         for (int s = 0; s < MAX_SETS; s++) begin
            if ((MUX_SETS_W+1)'(s) == set_ext) begin
               prev_in[s] = req_scan_bits;
            end
         end
      end
   end

   assign req_ready = q_space;
   assign q_push    = accept;
   assign q_data    = {~req_scan_bits, (ignore ? {PIN_COUNT{1'b0}} : changed)};

   always_ff @(posedge clock) begin
      if (reset) begin
         mux_sets_ff    <= (MUX_SETS_W+1)'(MAX_SETS);
         input_count_ff <= (INPUT_COUNT_W+1)'(PIN_COUNT);
         prev_ff        <= '{default: '0};
      end else begin
         mux_sets_ff    <= mux_sets_in;
         input_count_ff <= input_count_in;
         prev_ff        <= prev_in;
      end
   end

endmodule

### rtl/mbcr_queue.sv
module mbcr_queue import mbcr_pkg::*; #(
   parameter int WIDTH = 96
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             space,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             avail
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign space    = count_ff < CNT_W'(QUEUE_DEPTH);
   assign avail    = count_ff != '0;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/mbcr_back.sv
module mbcr_back import mbcr_pkg::*; #(
   parameter int PIN_COUNT = 48
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_avail,
   input  logic [2*PIN_COUNT-1:0] q_data,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp
);

   localparam int PW = $clog2(PIN_COUNT);

   back_state_type       state_ff, state_in;
   logic [PIN_COUNT-1:0] bits_ff, bits_in;
   logic [PIN_COUNT-1:0] prs_ff, prs_in;
   logic [PW-1:0]        pin_ff, pin_in;
   logic                 out_vld_ff, out_vld_in;
   rsp_type              out_ff, out_in;

   logic [PIN_COUNT-1:0] q_changed, q_pressed;
   logic                 out_free;
   logic                 rest_zero;
   logic                 advance;
   logic [6:0]           pin_ext;

   assign q_changed = q_data[PIN_COUNT-1:0];
   assign q_pressed = q_data[2*PIN_COUNT-1:PIN_COUNT];
   assign out_free  = !out_vld_ff || rsp_ready;
   assign rest_zero = (bits_ff >> 1) == '0;
   // a clear bit needs no output slot, so it always steps
   assign advance   = !bits_ff[0] || out_free;
   assign pin_ext   = 7'(pin_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_avail && out_free && (q_changed != '0)) begin
               state_in = BK_SCAN;
            end
         end
         BK_SCAN: begin
            if (advance && rest_zero) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      q_pop      = 1'b0;
      bits_in    = bits_ff;
      prs_in     = prs_ff;
      pin_in     = pin_ff;
      out_vld_in = out_vld_ff && !rsp_ready;
      out_in     = out_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_avail && out_free) begin
               q_pop = 1'b1;
               if (q_changed == '0) begin
                  out_vld_in = 1'b1;
                  out_in     = '{event_valid: 1'b0, pin_index: '0, scan_code: '0,
                                 key_code: '0, pressed: 1'b0, last: 1'b1};
               end else begin
                  bits_in = q_changed;
                  prs_in  = q_pressed;
                  pin_in  = '0;
               end
            end
         end
         BK_SCAN: begin
            if (advance) begin
               bits_in = bits_ff >> 1;
               prs_in  = prs_ff >> 1;
               pin_in  = pin_ff + 1'b1;
               if (bits_ff[0]) begin
                  out_vld_in = 1'b1;
                  out_in     = '{event_valid: 1'b1,
                                 pin_index: PIN_OUT_W'(pin_ext),
                                 scan_code: PIN_OUT_W'(pin_ext + 7'd1),
                                 key_code: key_code_f(pin_ext),
                                 pressed: prs_ff[0],
                                 last: rest_zero};
               end
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid = out_vld_ff;
   assign rsp       = out_ff;

   always_ff @(posedge clock) begin
      bits_ff <= bits_in;
      prs_ff  <= prs_in;
      pin_ff  <= pin_in;
      out_ff  <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BK_IDLE;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         out_vld_ff <= out_vld_in;
      end
   end

   a_scan_has_work: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_SCAN |-> bits_ff != '0)
      else $error("walker active with no changed bits left");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !out_ff.event_valid |-> out_ff.last)
      else $error("empty report not flagged last");

   a_code_follows_pin: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && out_ff.event_valid |->
         out_ff.scan_code == PIN_OUT_W'(out_ff.pin_index + 6'd1))
      else $error("scan code does not match pin");

   a_no_pop_while_scanning: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_SCAN |-> !q_pop)
      else $error("queue popped during a scan");

endmodule
